// ===== rtl/tridiagonal_system_solver_assert.svh =====
// Assertion macros for the tridiagonal system solver.
// Used by the top level; relies on clk and rst_n in the including scope.
`ifndef TRIDIAGONAL_SYSTEM_SOLVER_ASSERT_SVH
`define TRIDIAGONAL_SYSTEM_SOLVER_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define TSS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define TSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tss_pkg.sv =====
// Shared types and constants for the tridiagonal system solver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

    localparam int DATA_W = 32;
    localparam int ROW_W  = 6;

    typedef enum logic [1:0] {
        ALU_MUL = 2'b01,
        ALU_SUB = 2'b10
    } alu_op_t;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] num;
        logic signed [DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [DATA_W-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/tss_row_if.sv =====
// Input channel carrying one matrix row per transaction.
// Depends on tss_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tss_row_if;
    logic                             valid;
    logic                             ready;
    logic signed [tss_pkg::DATA_W-1:0] sub_diag;
    logic signed [tss_pkg::DATA_W-1:0] main_diag;
    logic signed [tss_pkg::DATA_W-1:0] super_diag;
    logic signed [tss_pkg::DATA_W-1:0] rhs;
    logic                             last_row;

    modport source (output valid, sub_diag, main_diag, super_diag, rhs, last_row,
                    input ready);
    modport sink   (input valid, sub_diag, main_diag, super_diag, rhs, last_row,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/tss_sol_if.sv =====
// Output channel carrying one solved unknown per transaction.
// Depends on tss_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tss_sol_if;
    logic                             valid;
    logic                             ready;
    logic signed [tss_pkg::DATA_W-1:0] solution_value;
    logic        [tss_pkg::ROW_W-1:0]  row_index;
    logic                             last_of_run;
    logic                             singular;

    modport source (output valid, solution_value, row_index, last_of_run, singular,
                    input ready);
    modport sink   (input valid, solution_value, row_index, last_of_run, singular,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/tss_alu.sv =====
// Shared multiply / subtract unit with saturation and a registered result.
// Depends on tss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tss_alu #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                             clk,
    input  wire tss_pkg::alu_op_t                 op,
    input  wire logic signed [tss_pkg::DATA_W-1:0] opa,
    input  wire logic signed [tss_pkg::DATA_W-1:0] opb,
    output logic signed [tss_pkg::DATA_W-1:0]      res
);

    localparam logic signed [2*tss_pkg::DATA_W-1:0] MAX_V = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [2*tss_pkg::DATA_W-1:0] MIN_V = -64'sh0000_0000_8000_0000;

    logic signed [2*tss_pkg::DATA_W-1:0] wide;
    logic signed [tss_pkg::DATA_W-1:0]   res_reg;
    logic signed [tss_pkg::DATA_W-1:0]   res_next;

    always_comb
    begin
        unique case (op)
            tss_pkg::ALU_MUL: wide = (64'(opa) * 64'(opb)) >>> FRAC_BITS;
            tss_pkg::ALU_SUB: wide = 64'(opa) - 64'(opb);
            default:          wide = '0;
        endcase
        if (wide > MAX_V)
            res_next = 32'sh7FFF_FFFF;
        else if (wide < MIN_V)
            res_next = 32'sh8000_0000;
        else
            res_next = wide[tss_pkg::DATA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== rtl/tss_div.sv =====
// Radix-2 restoring divider for (num << FRAC_BITS) / den, saturated.
// Depends on tss_pkg; one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module tss_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tss_pkg::div_req_t req,
    output tss_pkg::div_rsp_t      rsp
);

    localparam int NW = tss_pkg::DATA_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]                 n_reg;
    logic [tss_pkg::DATA_W-1:0]    d_reg;
    logic [tss_pkg::DATA_W:0]      rem_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic                          neg_reg;
    logic [tss_pkg::DATA_W:0]      trial;
    logic [tss_pkg::DATA_W:0]      shifted;
    logic [tss_pkg::DATA_W-1:0]    num_mag;
    logic [tss_pkg::DATA_W-1:0]    den_mag;
    logic signed [tss_pkg::DATA_W-1:0] quot;

    assign num_mag = req.num[tss_pkg::DATA_W-1] ? 32'(-req.num) : 32'(req.num);
    assign den_mag = req.den[tss_pkg::DATA_W-1] ? 32'(-req.den) : 32'(req.den);
    assign shifted = {rem_reg[tss_pkg::DATA_W-1:0], n_reg[NW-1]};
    assign trial   = shifted - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            n_reg   <= {num_mag, {FRAC_BITS{1'b0}}};
            d_reg   <= den_mag;
            rem_reg <= '0;
            neg_reg <= req.num[tss_pkg::DATA_W-1] ^ req.den[tss_pkg::DATA_W-1];
        end
        else if (busy_reg)
        begin
            // quotient bits shift into the vacated low end of n_reg
            if (!trial[tss_pkg::DATA_W])
            begin
                rem_reg <= trial;
                n_reg   <= {n_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                n_reg   <= {n_reg[NW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (!neg_reg)
        begin
            if (n_reg > NW'(33'h0_7FFF_FFFF))
                quot = 32'sh7FFF_FFFF;
            else
                quot = n_reg[tss_pkg::DATA_W-1:0];
        end
        else
        begin
            if (n_reg > NW'(33'h0_8000_0000))
                quot = 32'sh8000_0000;
            else
                quot = 32'(-n_reg[tss_pkg::DATA_W-1:0]);
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot;

endmodule

`default_nettype wire

// ===== rtl/tridiagonal_system_solver.sv =====
// Top level of the tridiagonal system solver (Thomas algorithm, fixed point).
// Depends on tss_pkg, tss_row_if, tss_sol_if, tss_alu, tss_div and the assert header.
//
//  channel   | dir | modport | payload
//  ----------+-----+---------+-----------------------------------------------
//  row_in    | in  | sink    | sub_diag, main_diag, super_diag, rhs, last_row
//  sol_out   | out | source  | solution_value, row_index, last_of_run, singular
//
// The first row of a system is stored as it arrives; every later row goes
// through the bit-serial divider, then two multiplies and two subtracts
// through the shared ALU.
// On the last row, back substitution runs a multiply, a subtract and a divide
// per solved row and waits while sol_out stalls; a zero pivot skips the
// divider. row_in is ready only when idle.
// Reset clears the sequencer, row count, pivot flag and output valid; the
// row stores need no clearing since only rows of the current system are read.
`timescale 1ns / 1ps
`default_nettype none

module tridiagonal_system_solver #(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tss_row_if.sink    row_in,
    tss_sol_if.source  sol_out
);

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_F_RD   = 15'b000000000000010,
        S_F_DIV  = 15'b000000000000100,
        S_F_DWT  = 15'b000000000001000,
        S_F_MUL1 = 15'b000000000010000,
        S_F_SUB1 = 15'b000000000100000,
        S_F_MUL2 = 15'b000000001000000,
        S_F_SUB2 = 15'b000000010000000,
        S_F_WR   = 15'b000000100000000,
        S_B_INIT = 15'b000001000000000,
        S_B_RD   = 15'b000010000000000,
        S_B_MUL  = 15'b000100000000000,
        S_B_SUB  = 15'b001000000000000,
        S_B_DIV  = 15'b010000000000000,
        S_B_OUT  = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    // Row stores: modified pivot, modified right side, super-diagonal
    logic signed [tss_pkg::DATA_W-1:0] piv_mem [MAX_ROWS];
    logic signed [tss_pkg::DATA_W-1:0] mr_mem  [MAX_ROWS];
    logic signed [tss_pkg::DATA_W-1:0] up_mem  [MAX_ROWS];
    logic signed [tss_pkg::DATA_W-1:0] piv_rd_reg, mr_rd_reg, up_rd_reg;

    logic                              mem_we;
    logic [AW-1:0]                     mem_ra;
    logic signed [tss_pkg::DATA_W-1:0] wr_piv, wr_mr;

    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] k_reg;
    logic          zp_reg;
    logic          first_reg;
    logic          last_reg;
    logic signed [tss_pkg::DATA_W-1:0] b_reg, d_reg, a_reg, c_reg;
    logic signed [tss_pkg::DATA_W-1:0] m_reg, piv_new_reg, u_reg, next_sol_reg;

    logic                              out_valid_reg;
    logic signed [tss_pkg::DATA_W-1:0] out_val_reg;
    logic [tss_pkg::ROW_W-1:0]         out_idx_reg;
    logic                              out_last_reg;
    logic                              out_sing_reg;

    tss_pkg::alu_op_t                  alu_op;
    logic signed [tss_pkg::DATA_W-1:0] alu_a, alu_b, alu_res;
    tss_pkg::div_req_t                 div_req;
    tss_pkg::div_rsp_t                 div_rsp;

    logic row_acc;
    logic out_free;
    logic room;

    assign row_in.ready = (state_reg == S_IDLE);
    assign row_acc      = row_in.valid && row_in.ready;
    assign out_free     = !out_valid_reg || sol_out.ready;
    assign room         = (cnt_reg < CW'(MAX_ROWS));

    tss_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .clk (clk),
        .op  (alu_op),
        .opa (alu_a),
        .opb (alu_b),
        .res (alu_res)
    );

    tss_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Shared unit operand selection
    always_comb
    begin
        alu_op = tss_pkg::ALU_MUL;
        alu_a  = m_reg;
        alu_b  = up_rd_reg;
        unique case (state_reg)
            S_F_SUB1:
            begin
                alu_op = tss_pkg::ALU_SUB;
                alu_a  = d_reg;
                alu_b  = alu_res;
            end
            S_F_MUL2:
            begin
                alu_a = m_reg;
                alu_b = mr_rd_reg;
            end
            S_F_SUB2:
            begin
                alu_op = tss_pkg::ALU_SUB;
                alu_a  = c_reg;
                alu_b  = alu_res;
            end
            S_B_MUL:
            begin
                alu_a = up_rd_reg;
                alu_b = next_sol_reg;
            end
            S_B_SUB:
            begin
                alu_op = tss_pkg::ALU_SUB;
                alu_a  = mr_rd_reg;
                alu_b  = alu_res;
            end
            default:
            begin
                alu_op = tss_pkg::ALU_MUL;
            end
        endcase
    end

    // Divider request: multiplier in forward pass, solution in back pass
    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = b_reg;
        div_req.den   = piv_rd_reg;
        if (state_reg == S_F_DIV)
            div_req.start = (piv_rd_reg != '0);
        else if (state_reg == S_B_DIV)
        begin
            div_req.start = (piv_rd_reg != '0) && !div_rsp.busy && !div_rsp.done
                            && (u_reg == '0) && 1'b1;
            div_req.num   = first_reg ? mr_rd_reg : alu_res;
        end
    end

    // Store ports: write at the row count, read at the row selected by the phase
    assign mem_ra = (state_reg == S_F_RD || state_reg == S_F_DIV || state_reg == S_F_DWT
                     || state_reg == S_F_MUL1 || state_reg == S_F_SUB1
                     || state_reg == S_F_MUL2 || state_reg == S_F_SUB2)
                    ? AW'(cnt_reg - 1'b1) : k_reg;
    assign mem_we = (row_acc && room && (cnt_reg == '0)) || (state_reg == S_F_WR);
    assign wr_piv = (state_reg == S_F_WR) ? piv_new_reg : row_in.main_diag;
    assign wr_mr  = (state_reg == S_F_WR) ? alu_res : row_in.rhs;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            piv_mem[cnt_reg[AW-1:0]] <= wr_piv;
            mr_mem[cnt_reg[AW-1:0]]  <= wr_mr;
            up_mem[cnt_reg[AW-1:0]]  <= (state_reg == S_F_WR) ? a_reg : row_in.super_diag;
        end
        piv_rd_reg <= piv_mem[mem_ra];
        mr_rd_reg  <= mr_mem[mem_ra];
        up_rd_reg  <= up_mem[mem_ra];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (row_acc)
                begin
                    if (room && (cnt_reg != '0))
                        state_next = S_F_RD;
                    else if (row_in.last_row)
                        state_next = S_B_INIT;
                end
            end
            S_F_RD:   state_next = S_F_DIV;
            S_F_DIV:  state_next = S_F_DWT;
            S_F_DWT:
            begin
                if ((piv_rd_reg == '0) || div_rsp.done)
                    state_next = S_F_MUL1;
            end
            S_F_MUL1: state_next = S_F_SUB1;
            S_F_SUB1: state_next = S_F_MUL2;
            S_F_MUL2: state_next = S_F_SUB2;
            S_F_SUB2: state_next = S_F_WR;
            S_F_WR:   state_next = last_reg ? S_B_INIT : S_IDLE;
            S_B_INIT: state_next = S_B_RD;
            S_B_RD:   state_next = S_B_MUL;
            S_B_MUL:  state_next = S_B_SUB;
            S_B_SUB:  state_next = S_B_DIV;
            S_B_DIV:
            begin
                if ((piv_rd_reg == '0) || div_rsp.done)
                    state_next = S_B_OUT;
            end
            S_B_OUT:
            begin
                if (out_free)
                    state_next = (k_reg == '0) ? S_IDLE : S_B_RD;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            zp_reg        <= 1'b0;
            next_sol_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (sol_out.ready)
                out_valid_reg <= 1'b0;
            if (row_acc && room && (cnt_reg == '0))
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (row_in.main_diag == '0)
                    zp_reg <= 1'b1;
            end
            if (state_reg == S_F_WR)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (piv_new_reg == '0)
                    zp_reg <= 1'b1;
            end
            if ((state_reg == S_B_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
                next_sol_reg  <= u_reg;
                if (k_reg == '0)
                begin
                    cnt_reg <= '0;
                    zp_reg  <= 1'b0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (row_acc)
        begin
            b_reg    <= row_in.sub_diag;
            d_reg    <= row_in.main_diag;
            a_reg    <= row_in.super_diag;
            c_reg    <= row_in.rhs;
            last_reg <= row_in.last_row;
        end
        if (state_reg == S_F_DWT)
            m_reg <= (piv_rd_reg == '0) ? '0 : div_rsp.quot;
        if (state_reg == S_F_MUL2)
            piv_new_reg <= alu_res;
        if (state_reg == S_B_INIT)
        begin
            k_reg     <= AW'(cnt_reg - 1'b1);
            first_reg <= 1'b1;
        end
        // hold zero while waiting so the divider starts exactly once
        if (state_reg == S_B_MUL)
            u_reg <= '0;
        if ((state_reg == S_B_DIV) && div_rsp.done)
            u_reg <= div_rsp.quot;
        if ((state_reg == S_B_OUT) && out_free)
        begin
            out_val_reg  <= u_reg;
            out_idx_reg  <= tss_pkg::ROW_W'(k_reg);
            out_last_reg <= (k_reg == '0);
            out_sing_reg <= zp_reg;
            first_reg    <= 1'b0;
            k_reg        <= k_reg - 1'b1;
        end
    end

    assign sol_out.valid          = out_valid_reg;
    assign sol_out.solution_value = out_val_reg;
    assign sol_out.row_index      = out_idx_reg;
    assign sol_out.last_of_run    = out_last_reg;
    assign sol_out.singular       = out_sing_reg;

    `include "tridiagonal_system_solver_assert.svh"

    `TSS_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_reg <= CW'(MAX_ROWS), "row count above capacity")
    `TSS_ASSERT_SAME(a_ready_idle, row_in.ready, !div_rsp.busy, "row taken while dividing")
    `TSS_ASSERT_SAME(a_div_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
    `TSS_ASSERT_NEXT(a_back_start, state_reg == S_B_INIT, cnt_reg != '0, "back pass on no rows")

endmodule

`default_nettype wire

// ===== verif/tss_tb_if.sv =====
// Testbench-side note: interfaces come from the RTL (tss_row_if, tss_sol_if).
// This file holds a small helper package of row and solution types; depends on tss_pkg.
`timescale 1ns / 1ps

package tss_tb_pkg;
    import tss_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] sub_diag;
        logic signed [DATA_W-1:0] main_diag;
        logic signed [DATA_W-1:0] super_diag;
        logic signed [DATA_W-1:0] rhs;
        logic                     last_row;
    } row_t;

    typedef struct {
        logic signed [DATA_W-1:0] solution_value;
        logic        [ROW_W-1:0]  row_index;
        logic                     last_of_run;
        logic                     singular;
    } sol_t;
endpackage

// ===== verif/testbench.sv =====
// Self-checking testbench for tridiagonal_system_solver.
// Depends on tss_pkg, tss_tb_pkg and the RTL interfaces tss_row_if and tss_sol_if.
`timescale 1ns / 1ps

module testbench;
    import tss_pkg::*;
    import tss_tb_pkg::*;

    localparam int MAX_ROWS   = 64;
    localparam int FRAC       = 16;
    localparam int IDLE_LIMIT = 400000;
    localparam logic signed [31:0] QMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] QMIN = 32'sh80000000;

    logic clk;
    logic rst_n;

    tss_row_if row_in ();
    tss_sol_if sol_out ();

    tridiagonal_system_solver #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .row_in  (row_in),
        .sol_out (sol_out)
    );

    // Shadow copy of the elimination state
    logic signed [31:0] pivots [MAX_ROWS];
    logic signed [31:0] mod_rhs [MAX_ROWS];
    logic signed [31:0] uppers [MAX_ROWS];
    int                 rows_held;
    logic signed [31:0] below_solution;
    logic               pivot_was_zero;

    sol_t solutions_due [$];
    int   mismatches;
    int   idle_cycles;
    bit   timed_out;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Saturate an exact wide value to the 32-bit signed range.
    function automatic logic signed [31:0] clamp32(input logic signed [95:0] v);
        if (v > QMAX)
            return QMAX;
        if (v < QMIN)
            return QMIN;
        return v[31:0];
    endfunction

    // Product shifted down with rounding toward minus infinity (arithmetic shift).
    function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [95:0] p;
        p = 96'(a) * 96'(b);
        return clamp32(p >>> FRAC);
    endfunction

    function automatic logic signed [31:0] q_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return clamp32(96'(a) - 96'(b));
    endfunction

    // Division truncating toward zero; caller guarantees a nonzero divisor.
    function automatic logic signed [31:0] q_div(input logic signed [31:0] n,
                                                 input logic signed [31:0] d);
        logic signed [95:0] wide;
        wide = 96'(n) <<< FRAC;
        return clamp32(wide / 96'(d));
    endfunction

    // Run one row through forward elimination; on the last row queue the solutions.
    task automatic eliminate_row(input row_t row);
        logic signed [31:0] piv;
        logic signed [31:0] mr;
        logic signed [31:0] factor;
        logic signed [31:0] num;
        logic signed [31:0] x;
        sol_t s;
        int n;
        if (rows_held < MAX_ROWS)
        begin
            if (rows_held == 0)
            begin
                piv = row.main_diag;
                mr  = row.rhs;
            end
            else
            begin
                factor = 0;
                if (pivots[rows_held-1] != 0)
                    factor = q_div(row.sub_diag, pivots[rows_held-1]);
                piv = q_sub(row.main_diag, q_mul(factor, uppers[rows_held-1]));
                mr  = q_sub(row.rhs, q_mul(factor, mod_rhs[rows_held-1]));
            end
            if (piv == 0)
                pivot_was_zero = 1'b1;
            pivots[rows_held]  = piv;
            mod_rhs[rows_held] = mr;
            uppers[rows_held]  = row.super_diag;
            rows_held++;
        end
        if (!row.last_row)
            return;
        n = rows_held;
        for (int k = n - 1; k >= 0; k--)
        begin
            num = mod_rhs[k];
            if (k != n - 1)
                num = q_sub(num, q_mul(uppers[k], below_solution));
            x = 0;
            if (pivots[k] != 0)
                x = q_div(num, pivots[k]);
            below_solution   = x;
            s.solution_value = x;
            s.row_index      = ROW_W'(k);
            s.last_of_run    = (k == 0);
            s.singular       = pivot_was_zero;
            solutions_due.push_back(s);
        end
        rows_held      = 0;
        pivot_was_zero = 1'b0;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one row and hold it until the transaction completes; valid stays
    // high afterwards so back-to-back rows need no second drive in one step.
    task automatic send_row(input row_t row);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            row_in.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        row_in.valid      <= 1'b1;
        row_in.sub_diag   <= row.sub_diag;
        row_in.main_diag  <= row.main_diag;
        row_in.super_diag <= row.super_diag;
        row_in.rhs        <= row.rhs;
        row_in.last_row   <= row.last_row;
        do
            @(posedge clk);
        while (!row_in.ready);
        eliminate_row(row);
    endtask

    function automatic row_t mk_row(input logic signed [31:0] b, d, a, c, input logic last);
        row_t r;
        r.sub_diag = b; r.main_diag = d; r.super_diag = a; r.rhs = c; r.last_row = last;
        return r;
    endfunction

    // Modest Q16.16 value around +-range units, occasionally any 32-bit pattern.
    function automatic logic signed [31:0] rand_q(input int range_units);
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $signed($urandom_range(0, 2 * range_units * 65536)) - range_units * 65536;
    endfunction

    // Send a full random system of n rows.
    task automatic send_system(input int n);
        for (int i = 0; i < n; i++)
            send_row(mk_row(rand_q(4), rand_q(64) + 32'sh00200000, rand_q(4), rand_q(100),
                            i == n - 1));
    endtask

    // Drop valid and hold until every queued solution has come back.
    task automatic wait_drained();
        row_in.valid <= 1'b0;
        while (solutions_due.size() != 0 && !timed_out)
            @(posedge clk);
    endtask

    task automatic test_single_rows();
        send_row(mk_row(0, 32'sh00020000, 0, 32'sh00010000, 1'b1));
        send_row(mk_row(QMAX, QMAX, QMAX, QMAX, 1'b1));
        send_row(mk_row(QMIN, QMIN, QMIN, QMIN, 1'b1));
        send_row(mk_row(0, 32'sh00000001, 0, QMIN, 1'b1)); // saturating divide
        send_row(mk_row(0, 0, 0, 32'sh00050000, 1'b1));    // zero pivot
        send_row(mk_row(0, 32'shFFFFFFFF, 0, QMIN, 1'b1)); // overflow on sign flip
    endtask

    task automatic test_small_systems();
        send_row(mk_row(0, 32'sh00040000, 32'sh00010000, 32'sh00050000, 1'b0));
        send_row(mk_row(32'sh00010000, 32'sh00040000, 0, 32'sh00050000, 1'b1));
        // Zero pivot in a later row
        send_row(mk_row(0, 32'sh00010000, 32'sh00010000, 32'sh00010000, 1'b0));
        send_row(mk_row(32'sh00010000, 32'sh00010000, QMIN, 32'sh00010000, 1'b0));
        send_row(mk_row(QMAX, QMIN, QMAX, QMIN, 1'b1));
        // Multiplier and subtract saturation
        send_row(mk_row(0, 32'sh00000001, QMAX, QMAX, 1'b0));
        send_row(mk_row(QMAX, QMIN, QMIN, QMIN, 1'b1));
    endtask

    // Fill all rows, then overflow rows that are dropped save their last mark.
    task automatic test_capacity();
        for (int i = 0; i < MAX_ROWS + 2; i++)
            send_row(mk_row(rand_q(2), 32'sh00080000, rand_q(2), rand_q(50),
                            i == MAX_ROWS + 1));
    endtask

    task automatic test_random();
        int n;
        for (int sys = 0; sys < 26; sys++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                // Raw patterns: random bits in every data field
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    send_row(mk_row($urandom, $urandom, $urandom, $urandom, i == n - 1));
            end
            else
                send_system($urandom_range(1, 8));
            if (sys == 12)
                wait_drained();   // hold the sender until every solution is back
        end
    endtask

    // Randomly stall the result side.
    initial
    begin
        int g;
        sol_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            g = gap_len();
            sol_out.ready <= (g == 0);
            @(posedge clk);
            if (g != 0)
            begin
                repeat (g - 1) @(posedge clk);
                sol_out.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each accepted solution with the oldest one outstanding.
    always @(posedge clk)
    begin
        sol_t want;
        bit bad;
        if (rst_n && sol_out.valid && sol_out.ready)
        begin
            if (solutions_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected solution row %0d value %0d",
                             sol_out.row_index, sol_out.solution_value);
            end
            else
            begin
                want = solutions_due.pop_front();
                bad = (sol_out.solution_value !== want.solution_value)
                   || (sol_out.row_index !== want.row_index)
                   || (sol_out.last_of_run !== want.last_of_run)
                   || (sol_out.singular !== want.singular);
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp val %0d row %0d last %0b sing %0b, got val %0d row %0d last %0b sing %0b",
                                 want.solution_value, want.row_index, want.last_of_run,
                                 want.singular, sol_out.solution_value, sol_out.row_index,
                                 sol_out.last_of_run, sol_out.singular);
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either channel.
    always @(posedge clk)
    begin
        if ((row_in.valid && row_in.ready) || (sol_out.valid && sol_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
            timed_out <= 1'b1;
    end

    initial
    begin
        wait (timed_out);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rows_held      = 0;
        below_solution = 0;
        pivot_was_zero = 1'b0;
        mismatches     = 0;
        idle_cycles    = 0;
        timed_out      = 1'b0;
        rst_n             = 1'b0;
        row_in.valid      = 1'b0;
        row_in.sub_diag   = '0;
        row_in.main_diag  = '0;
        row_in.super_diag = '0;
        row_in.rhs        = '0;
        row_in.last_row   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_rows();
        test_small_systems();
        test_capacity();
        test_random();

        wait_drained();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && solutions_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/tss_pkg.sv
rtl/tss_row_if.sv
rtl/tss_sol_if.sv
rtl/tss_alu.sv
rtl/tss_div.sv
rtl/tridiagonal_system_solver.sv
verif/tss_tb_if.sv
verif/testbench.sv
